@@ rtl/sclp_pkg.sv @@
`timescale 1ns / 1ps

package sclp_pkg;

   // Command codes on the result channel
   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_HEAT_ON   = 3'd1,
      CMD_HEAT_OFF  = 3'd2,
      CMD_LIGHT_ON  = 3'd3,
      CMD_LIGHT_OFF = 3'd4,
      CMD_MIST      = 3'd5
   } cmd_code_type;

   // Argument scanner phases
   typedef enum logic [1:0] {
      ARG_SKIP   = 2'd0,
      ARG_DIGITS = 2'd1,
      ARG_DONE   = 2'd2
   } arg_phase_type;

   localparam int unsigned KW_COUNT = 5;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   localparam logic [3:0] WORD_MAX = 4'd15;

   // Keyword lengths: heaton, heatoff, lighton, lightoff, mist
   function automatic logic [3:0] kw_len(input logic [2:0] k);
      logic [3:0] len;
      begin
         case (k)
            3'd0:    len = 4'd6;
            3'd1:    len = 4'd7;
            3'd2:    len = 4'd7;
            3'd3:    len = 4'd8;
            3'd4:    len = 4'd4;
            default: len = 4'd0;
         endcase
         return len;
      end
   endfunction

   // Keyword character at a position; positions past the end give NUL
   function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [3:0] pos);
      logic [63:0] text;
      logic [7:0]  ch;
      begin
         case (k)
            3'd0:    text = {"heaton", 16'h0};
            3'd1:    text = {"heatoff", 8'h0};
            3'd2:    text = {"lighton", 8'h0};
            3'd3:    text = "lightoff";
            3'd4:    text = {"mist", 32'h0};
            default: text = 64'h0;
         endcase
         if (pos < 4'd8) begin
            ch = text[8'd63 - {pos[2:0], 3'b000} -: 8];
         end else begin
            ch = CHAR_NUL;
         end
         return ch;
      end
   endfunction

endpackage

@@ rtl/serial_command_line_parser.sv @@
`timescale 1ns / 1ps

// Serial command line parser.
// req channel: one received byte per word (req_rx_byte), valid/stall handshake.
// Bytes build a line; the first word is matched on the fly against heaton,
// heatoff, lighton, lightoff and mist, and a decimal argument after it is
// accumulated as it arrives. A line feed ends the line.
// rsp channel: one word per line feed: rsp_command_code (0 = unknown) and
// rsp_mist_argument (nonzero only for mist), valid/stall handshake.
// Throughput: one byte per cycle while req_stall is low. Each byte updates the line
// state in the cycle it is taken; the result of a line feed is loaded into the
// output register and shows in the cycle after the line feed is accepted.
// Stall: the output register holds its word while rsp_stall is high; req_stall
// rises only while that register is full and stalled, so a new byte is taken in
// the same cycle the held word drains.
// Reset (synchronous, active high): empties the line and the output register.
// Overlong lines (LINE_CAPACITY-1 characters held) are cleared by the next
// non line feed byte, which is dropped.

module serial_command_line_parser
   import sclp_pkg::*;
#(
   parameter int unsigned LINE_CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_command_code,
   output logic signed [31:0] rsp_mist_argument
);

   localparam int unsigned LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_CAPACITY - 1);

   // line state
   logic [LEN_W-1:0]     line_length_ff, line_length_in;
   logic [3:0]           word_length_ff, word_length_in;
   logic                 word_ended_ff, word_ended_in;
   logic [KW_COUNT-1:0]  cand_ff, cand_in;
   arg_phase_type        phase_ff, phase_in;
   logic                 neg_ff, neg_in;
   logic [31:0]          value_ff, value_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   cmd_code_type         code_ff, code_in;
   logic [31:0]          arg_ff, arg_in;

   logic                 accept;
   logic                 is_space;
   logic                 is_digit;
   logic [31:0]          value_next;
   cmd_code_type         match_code;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign is_space = (req_rx_byte == CHAR_SPACE) ||
                     ((req_rx_byte >= CHAR_TAB) && (req_rx_byte <= CHAR_CR));
   assign is_digit = (req_rx_byte >= CHAR_ZERO) && (req_rx_byte <= CHAR_NINE);

   // value * 10 + digit
   assign value_next = (value_ff << 3) + (value_ff << 1) + {28'd0, req_rx_byte[3:0]};

   // first keyword still matching with the right length
   always_comb begin
      match_code = CMD_NONE;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (cand_ff[k] && (word_length_ff == kw_len(3'(k)))) begin
            match_code = cmd_code_type'(3'(k + 1));
         end
      end
   end

   // line state update
   always_comb begin
      line_length_in = line_length_ff;
      word_length_in = word_length_ff;
      word_ended_in  = word_ended_ff;
      cand_in        = cand_ff;
      phase_in       = phase_ff;
      neg_in         = neg_ff;
      value_in       = value_ff;
      code_in        = code_ff;
      arg_in         = arg_ff;

      if (accept) begin
         if ((req_rx_byte == CHAR_LF) || (line_length_ff >= LEN_FULL)) begin
            if (req_rx_byte == CHAR_LF) begin
               code_in = match_code;
               if (match_code == CMD_MIST) begin
                  arg_in = neg_ff ? (32'd0 - value_ff) : value_ff;
               end else begin
                  arg_in = 32'd0;
               end
            end
            line_length_in = '0;
            word_length_in = 4'd0;
            word_ended_in  = 1'b0;
            cand_in        = '1;
            phase_in       = ARG_SKIP;
            neg_in         = 1'b0;
            value_in       = 32'd0;
         end else if (req_rx_byte != CHAR_NUL) begin
            line_length_in = line_length_ff + LEN_W'(1);
            if (!word_ended_ff) begin
               if (req_rx_byte == CHAR_SPACE) begin
                  word_ended_in = 1'b1;
               end else begin
                  // drop keywords that no longer match the prefix
                  for (int k = 0; k < KW_COUNT; k++) begin
                     if (!((word_length_ff < kw_len(3'(k))) &&
                           (kw_char(3'(k), word_length_ff) == req_rx_byte))) begin
                        cand_in[k] = 1'b0;
                     end
                  end
                  if (word_length_ff < WORD_MAX) begin
                     word_length_in = word_length_ff + 4'd1;
                  end
               end
            end else begin
               // argument scanner
               case (phase_ff)
                  ARG_SKIP: begin
                     if (!is_space) begin
                        if ((req_rx_byte == CHAR_MINUS) || (req_rx_byte == CHAR_PLUS)) begin
                           neg_in   = (req_rx_byte == CHAR_MINUS);
                           phase_in = ARG_DIGITS;
                        end else if (is_digit) begin
                           value_in = value_next;
                           phase_in = ARG_DIGITS;
                        end else begin
                           phase_in = ARG_DONE;
                        end
                     end
                  end
                  ARG_DIGITS: begin
                     if (is_digit) begin
                        value_in = value_next;
                     end else begin
                        phase_in = ARG_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   // output valid: load on line feed, hold while stalled
   always_comb begin
      if (accept && (req_rx_byte == CHAR_LF)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
         word_length_ff <= 4'd0;
         word_ended_ff  <= 1'b0;
         cand_ff        <= '1;
         phase_ff       <= ARG_SKIP;
         neg_ff         <= 1'b0;
         value_ff       <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_length_ff <= line_length_in;
         word_length_ff <= word_length_in;
         word_ended_ff  <= word_ended_in;
         cand_ff        <= cand_in;
         phase_ff       <= phase_in;
         neg_ff         <= neg_in;
         value_ff       <= value_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      code_ff <= code_in;
      arg_ff  <= arg_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_command_code  = code_ff;
   assign rsp_mist_argument = $signed(arg_ff);

endmodule

@@ dv/tb_serial_command_line_parser.sv @@
`timescale 1ns / 1ps

module tb_serial_command_line_parser;
   import sclp_pkg::*;

   localparam int unsigned LINE_CAP    = 64;
   localparam int          CYCLE_LIMIT = 500000;

   // one result word as seen on the rsp channel
   typedef struct packed {
      cmd_code_type       code;
      logic signed [31:0] arg;
   } command_word_type;

   // Tracks the line state byte by byte and holds the commands still due
   class command_predictor;
      string            keyword[5];
      command_word_type expected_commands[$];
      int               errors;

      int unsigned   line_len;
      logic [3:0]    word_len;
      bit            word_done;
      logic [4:0]    cand;
      arg_phase_type phase;
      bit            neg;
      logic [31:0]   mag;

      function new();
         keyword = '{"heaton", "heatoff", "lighton", "lightoff", "mist"};
         errors  = 0;
         clear_line();
      endfunction

      function void clear_line();
         line_len  = 0;
         word_len  = 4'd0;
         word_done = 1'b0;
         cand      = 5'b11111;
         phase     = ARG_SKIP;
         neg       = 1'b0;
         mag       = 32'd0;
      endfunction

      function int pending();
         return expected_commands.size();
      endfunction

      // Update the line with one accepted byte; a line feed queues a command
      function void note_byte(logic [7:0] c);
         cmd_code_type     code;
         command_word_type w;
         bit               digit;
         digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
         if (c == CHAR_LF) begin
            code = CMD_NONE;
            // first surviving keyword of the right length wins; code = index + 1
            for (int k = 0; k < KW_COUNT; k++) begin
               if (code == CMD_NONE && cand[k] && word_len == keyword[k].len()) begin
                  code = cmd_code_type'(k + 1);
               end
            end
            w.code = code;
            w.arg  = (code == CMD_MIST) ? (neg ? -mag : mag) : 32'sd0;
            expected_commands.push_back(w);
            clear_line();
         end else if (line_len >= LINE_CAP - 1) begin
            // no room: byte dropped, line cleared
            clear_line();
         end else if (c != CHAR_NUL) begin
            line_len++;
            if (!word_done) begin
               if (c == CHAR_SPACE) begin
                  word_done = 1'b1;
               end else begin
                  for (int k = 0; k < KW_COUNT; k++) begin
                     if (!(word_len < keyword[k].len() && keyword[k][word_len] == c)) begin
                        cand[k] = 1'b0;
                     end
                  end
                  if (word_len < WORD_MAX) begin
                     word_len++;
                  end
               end
            end else if (phase == ARG_SKIP) begin
               if (!(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))) begin
                  if (c == CHAR_MINUS || c == CHAR_PLUS) begin
                     neg   = (c == CHAR_MINUS);
                     phase = ARG_DIGITS;
                  end else if (digit) begin
                     mag   = mag * 32'd10 + 32'(c - CHAR_ZERO);
                     phase = ARG_DIGITS;
                  end else begin
                     phase = ARG_DONE;
                  end
               end
            end else if (phase == ARG_DIGITS) begin
               if (digit) begin
                  mag = mag * 32'd10 + 32'(c - CHAR_ZERO);
               end else begin
                  phase = ARG_DONE;
               end
            end
         end
      endfunction

      // Compare one accepted result word against the oldest expected command
      function void check_command(logic [2:0] code, logic signed [31:0] arg);
         command_word_type w;
         if (expected_commands.size() == 0) begin
            $error("unexpected result word: command_code=%0d mist_argument=%0d", code, arg);
            errors++;
         end else begin
            w = expected_commands.pop_front();
            if (code !== w.code) begin
               $error("command_code: expected %0d, got %0d", w.code, code);
               errors++;
            end
            if (arg !== w.arg) begin
               $error("mist_argument: expected %0d, got %0d", w.arg, arg);
               errors++;
            end
         end
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic [2:0]         rsp_command_code;
   logic signed [31:0] rsp_mist_argument;

   command_predictor sb = new();

   bit quiet      = 1'b0;
   int gap_pct    = 20;
   int bytes_sent = 0;
   int cycles     = 0;
   int rsp_run    = 0;
   bit rsp_hold   = 1'b0;

   serial_command_line_parser #(.LINE_CAPACITY(LINE_CAP)) uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_command_code  (rsp_command_code),
      .rsp_mist_argument (rsp_mist_argument)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // timeout
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("serial_command_line_parser: mismatch");
         $finish;
      end
   end

   // rsp side: random stall bursts between free stretches
   always @(posedge clock) begin
      if (rsp_run == 0) begin
         rsp_hold = !quiet && ($urandom_range(0, 2) == 0);
         rsp_run  = rsp_hold ? $urandom_range(1, 7) : $urandom_range(1, 20);
      end
      rsp_run--;
      rsp_stall <= rsp_hold && !quiet;
   end

   // monitor both channels at the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_command(rsp_command_code, rsp_mist_argument);
      end
      if (!reset && req_valid && !req_stall) begin
         sb.note_byte(req_rx_byte);
      end
   end

   // Offer one byte, with an optional idle burst first; return once accepted
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_str(input string s);
      for (int i = 0; i < s.len(); i++) begin
         send_byte(s[i]);
      end
   endtask

   initial begin
      byte unsigned line_bytes[$];
      string        w;
      int           sel;
      int           n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: every command, argument extremes and corner cases
      send_str("heaton\n");
      send_str("heatoff\n");
      send_str("lighton\n");
      send_str("lightoff\n");
      send_str("mist\n");
      send_str("mist -2147483648\n");
      send_str("mist 2147483647\n");
      send_str("mist +7\n");
      send_str("mist 4294967296\n");
      send_str("mist -99999999999\n");
      send_str("mist \t\013\014\015 42\n");
      send_str("mist -\n");
      send_str("mist 12ab\n");
      send_str("mist x5\n");
      send_str("\n");
      send_str("hea");
      send_byte(CHAR_NUL);
      send_str("ton\n");
      send_str("heatonx\n");
      send_str("abcdefghijklmnopqrs\n");
      send_str("mist\t5\n");
      send_str(" heaton\n");
      send_byte(8'hFF);
      send_byte(CHAR_LF);
      // full line, next byte clears it
      repeat (LINE_CAP - 1) send_byte("x");
      send_byte("y");
      send_str("lighton\n");
      // full line cleared by a zero byte
      repeat (LINE_CAP - 1) send_byte("z");
      send_byte(CHAR_NUL);
      send_str("mist 5\n");
      // exactly full line, then line feed
      send_str("mist ");
      repeat (LINE_CAP - 6) send_byte("9");
      send_byte(CHAR_LF);

      // random lines: mostly well-formed commands, some noise and junk
      while (bytes_sent < 1940) begin
         if (bytes_sent > 1700) quiet = 1'b1;
         gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
         line_bytes.delete();
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            w = sb.keyword[$urandom_range(0, KW_COUNT - 1)];
            for (int i = 0; i < w.len(); i++) line_bytes.push_back(w[i]);
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 1)) void'(line_bytes.pop_back());
               else line_bytes.push_back($urandom_range("a", "z"));
            end
            if ($urandom_range(0, 19) == 0) begin
               line_bytes.insert($urandom_range(0, line_bytes.size()), CHAR_NUL);
            end
            if (w == "mist" || $urandom_range(0, 1)) begin
               line_bytes.push_back(CHAR_SPACE);
               repeat ($urandom_range(0, 3)) begin
                  case ($urandom_range(0, 4))
                     0:       line_bytes.push_back(CHAR_SPACE);
                     1:       line_bytes.push_back(CHAR_TAB);
                     2:       line_bytes.push_back(8'h0B);
                     3:       line_bytes.push_back(8'h0C);
                     default: line_bytes.push_back(CHAR_CR);
                  endcase
               end
               case ($urandom_range(0, 3))
                  0:       line_bytes.push_back(CHAR_MINUS);
                  1:       line_bytes.push_back(CHAR_PLUS);
                  default: ;
               endcase
               repeat ($urandom_range(0, 12)) line_bytes.push_back($urandom_range(CHAR_ZERO, CHAR_NINE));
               if ($urandom_range(0, 4) == 0) line_bytes.push_back($urandom_range(8'h21, 8'h7E));
               if ($urandom_range(0, 9) == 0) line_bytes.push_back(CHAR_NUL);
            end
            line_bytes.push_back(CHAR_LF);
         end else if (sel < 80) begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 20)) line_bytes.push_back($urandom_range(0, 255));
            if ($urandom_range(0, 1)) line_bytes.push_back(CHAR_LF);
         end else if (sel < 90) begin
            // overlong first word
            n = $urandom_range(9, 20);
            repeat (n) line_bytes.push_back($urandom_range("a", "z"));
            line_bytes.push_back(CHAR_LF);
         end else if (sel < 95) begin
            line_bytes.push_back(CHAR_LF);
         end else begin
            // line that may run past capacity
            w = "mist ";
            for (int i = 0; i < w.len(); i++) line_bytes.push_back(w[i]);
            repeat ($urandom_range(50, 80)) line_bytes.push_back($urandom_range(8'h21, 8'h7E));
            line_bytes.push_back(CHAR_LF);
         end
         foreach (line_bytes[i]) send_byte(line_bytes[i]);
      end
      req_valid <= 1'b0;

      // drain
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("serial_command_line_parser: match");
      end else begin
         $display("serial_command_line_parser: mismatch");
      end
      $finish;
   end

endmodule

@@ serial_command_line_parser.f @@
rtl/sclp_pkg.sv
rtl/serial_command_line_parser.sv
dv/tb_serial_command_line_parser.sv
